### hdl/segment_intersection_point_top_assert.svh
// assertion macros for the segment crossing block
`ifndef SEGMENT_INTERSECTION_POINT_TOP_ASSERT_SVH
`define SEGMENT_INTERSECTION_POINT_TOP_ASSERT_SVH

// same-cycle implication
`define SIP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sip assertion failed");

// next-cycle implication
`define SIP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sip assertion failed");

`endif

### hdl/sip_pkg.sv
package sip_pkg;

    localparam int COORD_BITS_DEF = 15;
    localparam int FRAC_BITS_DEF  = 16;

    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
    } t_tag;

endpackage

### hdl/segment_intersection_point_top.sv
// channel  dir  handshake                  payload
// in       in   i_in_valid / o_in_ready    i_first_{p,q}_{x,y}, i_second_{p,q}_{x,y}
// out      out  o_out_valid / i_out_ready  o_found, o_cross_x, o_cross_y
//
// one transfer per cycle on each side while neither side stalls
// results pass through the seven-stage cross product front end, the
// one-bit-per-stage divider and the output register
// synchronous active-low reset clears the valid bits only
// a held result freezes the pipeline; a one-entry skid takes one more transfer
`include "segment_intersection_point_top_assert.svh"

module segment_intersection_point_top
    import sip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [COORD_BITS-1:0]           i_first_p_x,
    input  logic signed [COORD_BITS-1:0]           i_first_p_y,
    input  logic signed [COORD_BITS-1:0]           i_first_q_x,
    input  logic signed [COORD_BITS-1:0]           i_first_q_y,
    input  logic signed [COORD_BITS-1:0]           i_second_p_x,
    input  logic signed [COORD_BITS-1:0]           i_second_p_y,
    input  logic signed [COORD_BITS-1:0]           i_second_q_x,
    input  logic signed [COORD_BITS-1:0]           i_second_q_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_found,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_cross_x,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_cross_y
);

    localparam int RW = 2 * COORD_BITS + 1;
    localparam int MW = 3 * COORD_BITS + 2;
    localparam int QB = COORD_BITS + FRAC_BITS;

    logic                         adv;

    logic                         r_skid_valid;
    logic signed [COORD_BITS-1:0] r_skid_p1x, r_skid_p1y, r_skid_q1x, r_skid_q1y;
    logic signed [COORD_BITS-1:0] r_skid_p2x, r_skid_p2y, r_skid_q2x, r_skid_q2y;

    logic                         f_valid;
    logic signed [COORD_BITS-1:0] f_p1x, f_p1y, f_q1x, f_q1y, f_p2x, f_p2y, f_q2x, f_q2y;

    t_tag                         f_tag;
    logic [MW-1:0]                f_num_x, f_num_y;
    logic [RW-1:0]                f_den;

    t_tag                         d_tag;
    logic [QB-1:0]                d_quo_x, d_quo_y;

    logic                         r_out_valid;
    logic                         r_found;
    logic [QB-1:0]                r_cross_x, r_cross_y;

    // pipeline moves when the output register is free or being emptied
    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_skid_valid;

    assign f_valid = r_skid_valid || i_in_valid;
    assign f_p1x   = r_skid_valid ? r_skid_p1x : i_first_p_x;
    assign f_p1y   = r_skid_valid ? r_skid_p1y : i_first_p_y;
    assign f_q1x   = r_skid_valid ? r_skid_q1x : i_first_q_x;
    assign f_q1y   = r_skid_valid ? r_skid_q1y : i_first_q_y;
    assign f_p2x   = r_skid_valid ? r_skid_p2x : i_second_p_x;
    assign f_p2y   = r_skid_valid ? r_skid_p2y : i_second_p_y;
    assign f_q2x   = r_skid_valid ? r_skid_q2x : i_second_q_x;
    assign f_q2y   = r_skid_valid ? r_skid_q2y : i_second_q_y;

    sip_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (adv),
        .i_valid      (f_valid),
        .i_first_p_x  (f_p1x),
        .i_first_p_y  (f_p1y),
        .i_first_q_x  (f_q1x),
        .i_first_q_y  (f_q1y),
        .i_second_p_x (f_p2x),
        .i_second_p_y (f_p2y),
        .i_second_q_x (f_q2x),
        .i_second_q_y (f_q2y),
        .o_tag        (f_tag),
        .o_num_x      (f_num_x),
        .o_num_y      (f_num_y),
        .o_den        (f_den)
    );

    sip_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_tag   (f_tag),
        .i_num_x (f_num_x),
        .i_num_y (f_num_y),
        .i_den   (f_den),
        .o_tag   (d_tag),
        .o_quo_x (d_quo_x),
        .o_quo_y (d_quo_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (adv) begin
                r_skid_valid <= 1'b0;
            end else if (i_in_valid && !r_skid_valid) begin
                r_skid_valid <= 1'b1;
            end
            if (!r_skid_valid) begin
                r_skid_p1x <= i_first_p_x;
                r_skid_p1y <= i_first_p_y;
                r_skid_q1x <= i_first_q_x;
                r_skid_q1y <= i_first_q_y;
                r_skid_p2x <= i_second_p_x;
                r_skid_p2y <= i_second_p_y;
                r_skid_q2x <= i_second_q_x;
                r_skid_q2y <= i_second_q_y;
            end
            if (adv) begin
                r_out_valid <= d_tag.valid;
                r_found     <= d_tag.hit;
                // magnitude quotient gets the numerator sign: rounds toward zero
                if (d_tag.hit) begin
                    r_cross_x <= d_tag.neg_x ? -d_quo_x : d_quo_x;
                    r_cross_y <= d_tag.neg_y ? -d_quo_y : d_quo_y;
                end else begin
                    r_cross_x <= '0;
                    r_cross_y <= '0;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_cross_x   = r_cross_x;
    assign o_cross_y   = r_cross_y;

    `SIP_ASSERT_IMP(a_hit_den, f_tag.valid && f_tag.hit, f_den != '0)
    `SIP_ASSERT_IMP(a_num_x_fit, f_tag.valid && f_tag.hit, f_num_x[MW-1:COORD_BITS] < f_den)
    `SIP_ASSERT_IMP(a_num_y_fit, f_tag.valid && f_tag.hit, f_num_y[MW-1:COORD_BITS] < f_den)
    `SIP_ASSERT_IMP(a_skid_fill, $rose(r_skid_valid), $past(!adv))

endmodule

### hdl/sip_front.sv
module sip_front
    import sip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_first_p_x,
    input  logic signed [COORD_BITS-1:0] i_first_p_y,
    input  logic signed [COORD_BITS-1:0] i_first_q_x,
    input  logic signed [COORD_BITS-1:0] i_first_q_y,
    input  logic signed [COORD_BITS-1:0] i_second_p_x,
    input  logic signed [COORD_BITS-1:0] i_second_p_y,
    input  logic signed [COORD_BITS-1:0] i_second_q_x,
    input  logic signed [COORD_BITS-1:0] i_second_q_y,
    output t_tag                         o_tag,
    output logic [3*COORD_BITS+1:0]      o_num_x,
    output logic [3*COORD_BITS+1:0]      o_num_y,
    output logic [2*COORD_BITS:0]        o_den
);

    localparam int DW = COORD_BITS + 1;
    localparam int XW = 2 * COORD_BITS + 2;
    localparam int RW = 2 * COORD_BITS + 1;
    localparam int NW = 3 * COORD_BITS + 3;
    localparam int MW = 3 * COORD_BITS + 2;

    // stage 1: differences
    logic                         r_s1_valid;
    logic signed [DW-1:0]         r_s1_d1x, r_s1_d1y, r_s1_d2x, r_s1_d2y, r_s1_rx, r_s1_ry;
    logic signed [COORD_BITS-1:0] r_s1_p1x, r_s1_p1y;
    // stage 2: partial cross products
    logic                         r_s2_valid;
    logic signed [XW-1:0]         r_s2_a, r_s2_b, r_s2_c, r_s2_d, r_s2_e, r_s2_f;
    logic signed [DW-1:0]         r_s2_d1x, r_s2_d1y;
    logic signed [COORD_BITS-1:0] r_s2_p1x, r_s2_p1y;
    // stage 3: cross products
    logic                         r_s3_valid;
    logic signed [XW-1:0]         r_s3_den, r_s3_sn, r_s3_tn;
    logic signed [DW-1:0]         r_s3_d1x, r_s3_d1y;
    logic signed [COORD_BITS-1:0] r_s3_p1x, r_s3_p1y;
    // stage 4: positive denominator
    logic                         r_s4_valid;
    logic signed [XW-1:0]         r_s4_den, r_s4_sn, r_s4_tn;
    logic signed [DW-1:0]         r_s4_d1x, r_s4_d1y;
    logic signed [COORD_BITS-1:0] r_s4_p1x, r_s4_p1y;
    // stage 5: hit test and numerator products
    logic                         r_s5_valid;
    logic                         r_s5_hit;
    logic signed [NW-1:0]         r_s5_pden_x, r_s5_pden_y, r_s5_dsn_x, r_s5_dsn_y;
    logic [RW-1:0]                r_s5_den;
    // stage 6: numerators
    logic                         r_s6_valid;
    logic                         r_s6_hit;
    logic signed [NW-1:0]         r_s6_sum_x, r_s6_sum_y;
    logic [RW-1:0]                r_s6_den;
    // stage 7: sign and magnitude
    logic                         r_s7_valid;
    logic                         r_s7_hit;
    logic                         r_s7_neg_x, r_s7_neg_y;
    logic [MW-1:0]                r_s7_mag_x, r_s7_mag_y;
    logic [RW-1:0]                r_s7_den;

    logic signed [NW-1:0]         n_mag_x, n_mag_y;

    always_comb begin
        n_mag_x = r_s6_sum_x[NW-1] ? -r_s6_sum_x : r_s6_sum_x;
        n_mag_y = r_s6_sum_y[NW-1] ? -r_s6_sum_y : r_s6_sum_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s1_d1x   <= DW'(i_first_q_x) - DW'(i_first_p_x);
            r_s1_d1y   <= DW'(i_first_q_y) - DW'(i_first_p_y);
            r_s1_d2x   <= DW'(i_second_q_x) - DW'(i_second_p_x);
            r_s1_d2y   <= DW'(i_second_q_y) - DW'(i_second_p_y);
            r_s1_rx    <= DW'(i_second_p_x) - DW'(i_first_p_x);
            r_s1_ry    <= DW'(i_second_p_y) - DW'(i_first_p_y);
            r_s1_p1x   <= i_first_p_x;
            r_s1_p1y   <= i_first_p_y;

            r_s2_valid <= r_s1_valid;
            r_s2_a     <= r_s1_d1x * r_s1_d2y;
            r_s2_b     <= r_s1_d1y * r_s1_d2x;
            r_s2_c     <= r_s1_rx * r_s1_d2y;
            r_s2_d     <= r_s1_ry * r_s1_d2x;
            r_s2_e     <= r_s1_rx * r_s1_d1y;
            r_s2_f     <= r_s1_ry * r_s1_d1x;
            r_s2_d1x   <= r_s1_d1x;
            r_s2_d1y   <= r_s1_d1y;
            r_s2_p1x   <= r_s1_p1x;
            r_s2_p1y   <= r_s1_p1y;

            r_s3_valid <= r_s2_valid;
            r_s3_den   <= r_s2_a - r_s2_b;
            r_s3_sn    <= r_s2_c - r_s2_d;
            r_s3_tn    <= r_s2_e - r_s2_f;
            r_s3_d1x   <= r_s2_d1x;
            r_s3_d1y   <= r_s2_d1y;
            r_s3_p1x   <= r_s2_p1x;
            r_s3_p1y   <= r_s2_p1y;

            r_s4_valid <= r_s3_valid;
            r_s4_den   <= r_s3_den[XW-1] ? -r_s3_den : r_s3_den;
            r_s4_sn    <= r_s3_den[XW-1] ? -r_s3_sn : r_s3_sn;
            r_s4_tn    <= r_s3_den[XW-1] ? -r_s3_tn : r_s3_tn;
            r_s4_d1x   <= r_s3_d1x;
            r_s4_d1y   <= r_s3_d1y;
            r_s4_p1x   <= r_s3_p1x;
            r_s4_p1y   <= r_s3_p1y;

            r_s5_valid  <= r_s4_valid;
            r_s5_hit    <= (r_s4_den != '0) && (r_s4_sn > 0) && (r_s4_sn < r_s4_den)
                           && (r_s4_tn > 0) && (r_s4_tn < r_s4_den);
            r_s5_pden_x <= r_s4_p1x * r_s4_den;
            r_s5_pden_y <= r_s4_p1y * r_s4_den;
            r_s5_dsn_x  <= r_s4_d1x * r_s4_sn;
            r_s5_dsn_y  <= r_s4_d1y * r_s4_sn;
            r_s5_den    <= r_s4_den[RW-1:0];

            r_s6_valid <= r_s5_valid;
            r_s6_hit   <= r_s5_hit;
            r_s6_sum_x <= r_s5_pden_x + r_s5_dsn_x;
            r_s6_sum_y <= r_s5_pden_y + r_s5_dsn_y;
            r_s6_den   <= r_s5_den;

            r_s7_valid <= r_s6_valid;
            r_s7_hit   <= r_s6_hit;
            r_s7_neg_x <= r_s6_sum_x[NW-1];
            r_s7_neg_y <= r_s6_sum_y[NW-1];
            r_s7_mag_x <= n_mag_x[MW-1:0];
            r_s7_mag_y <= n_mag_y[MW-1:0];
            r_s7_den   <= r_s6_den;
        end
    end

    assign o_tag   = '{valid: r_s7_valid, hit: r_s7_hit,
                       neg_x: r_s7_neg_x, neg_y: r_s7_neg_y};
    assign o_num_x = r_s7_mag_x;
    assign o_num_y = r_s7_mag_y;
    assign o_den   = r_s7_den;

endmodule

### hdl/sip_div.sv
module sip_div
    import sip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  t_tag                            i_tag,
    input  logic [3*COORD_BITS+1:0]         i_num_x,
    input  logic [3*COORD_BITS+1:0]         i_num_y,
    input  logic [2*COORD_BITS:0]           i_den,
    output t_tag                            o_tag,
    output logic [COORD_BITS+FRAC_BITS-1:0] o_quo_x,
    output logic [COORD_BITS+FRAC_BITS-1:0] o_quo_y
);

    localparam int RW = 2 * COORD_BITS + 1;
    localparam int QB = COORD_BITS + FRAC_BITS;

    // one quotient bit per stage; the low word shifts numerator bits out
    // and quotient bits in
    t_tag          r_tag   [QB];
    logic [RW-1:0] r_den   [QB];
    logic [RW-1:0] r_rem_x [QB];
    logic [RW-1:0] r_rem_y [QB];
    logic [QB-1:0] r_low_x [QB];
    logic [QB-1:0] r_low_y [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        t_tag          a_tag;
        logic [RW-1:0] a_den, a_rem_x, a_rem_y;
        logic [QB-1:0] a_low_x, a_low_y;
        logic [RW:0]   t_x, t_y, d_x, d_y;
        logic          q_x, q_y;

        if (k == 0) begin : g_head
            assign a_tag   = i_tag;
            assign a_den   = i_den;
            assign a_rem_x = i_num_x[COORD_BITS+RW-1:COORD_BITS];
            assign a_rem_y = i_num_y[COORD_BITS+RW-1:COORD_BITS];
            assign a_low_x = {i_num_x[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
            assign a_low_y = {i_num_y[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
        end else begin : g_body
            assign a_tag   = r_tag[k-1];
            assign a_den   = r_den[k-1];
            assign a_rem_x = r_rem_x[k-1];
            assign a_rem_y = r_rem_y[k-1];
            assign a_low_x = r_low_x[k-1];
            assign a_low_y = r_low_y[k-1];
        end

        assign t_x = {a_rem_x, a_low_x[QB-1]};
        assign t_y = {a_rem_y, a_low_y[QB-1]};
        assign q_x = (t_x >= {1'b0, a_den});
        assign q_y = (t_y >= {1'b0, a_den});
        assign d_x = t_x - {1'b0, a_den};
        assign d_y = t_y - {1'b0, a_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k].valid <= 1'b0;
            end else if (i_en) begin
                r_tag[k]   <= a_tag;
                r_den[k]   <= a_den;
                r_rem_x[k] <= q_x ? d_x[RW-1:0] : t_x[RW-1:0];
                r_rem_y[k] <= q_y ? d_y[RW-1:0] : t_y[RW-1:0];
                r_low_x[k] <= {a_low_x[QB-2:0], q_x};
                r_low_y[k] <= {a_low_y[QB-2:0], q_y};
            end
        end
    end

    assign o_tag   = r_tag[QB-1];
    assign o_quo_x = r_low_x[QB-1];
    assign o_quo_y = r_low_y[QB-1];

endmodule

### tb/sv/tb_segment_intersection_point_top.sv
module tb_segment_intersection_point_top;
    import sip_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int FW = FRAC_BITS_DEF;
    localparam int OW = CW + FW;
    localparam int N_RANDOM = 630;
    localparam int END_WAIT = OW + 16;

    typedef struct {
        logic signed [CW-1:0] p1x, p1y, q1x, q1y;
        logic signed [CW-1:0] p2x, p2y, q2x, q2y;
    } t_segment_pair;

    typedef struct {
        logic                 found;
        logic signed [OW-1:0] x;
        logic signed [OW-1:0] y;
    } t_crossing;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic signed [CW-1:0] i_first_p_x = '0;
    logic signed [CW-1:0] i_first_p_y = '0;
    logic signed [CW-1:0] i_first_q_x = '0;
    logic signed [CW-1:0] i_first_q_y = '0;
    logic signed [CW-1:0] i_second_p_x = '0;
    logic signed [CW-1:0] i_second_p_y = '0;
    logic signed [CW-1:0] i_second_q_x = '0;
    logic signed [CW-1:0] i_second_q_y = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_found;
    logic signed [OW-1:0] o_cross_x;
    logic signed [OW-1:0] o_cross_y;

    t_segment_pair pending_pairs[$];
    t_crossing     expected_crossings[$];
    t_segment_pair cur_pair;
    int            n_total = 0;
    int            n_sent = 0;
    int            n_received = 0;
    int            n_fail = 0;
    int            n_mismatch = 0;
    int            in_gap = 0;
    int            out_stall = 0;
    bit            in_burst = 1'b0;
    bit            out_burst = 1'b0;

    segment_intersection_point_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_first_p_x  (i_first_p_x),
        .i_first_p_y  (i_first_p_y),
        .i_first_q_x  (i_first_q_x),
        .i_first_q_y  (i_first_q_y),
        .i_second_p_x (i_second_p_x),
        .i_second_p_y (i_second_p_y),
        .i_second_q_x (i_second_q_x),
        .i_second_q_y (i_second_q_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_found      (o_found),
        .o_cross_x    (o_cross_x),
        .o_cross_y    (o_cross_y)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // p + d*sn/den in fixed point, truncated toward zero, den > 0
    function automatic longint point_along(longint p, longint d, longint sn, longint den);
        longint num;
        num = (p * den + d * sn) * (longint'(1) << FW);
        return num / den;
    endfunction

    function automatic t_crossing predict_crossing(t_segment_pair s);
        longint    d1x, d1y, d2x, d2y, rx, ry, den, sn, tn;
        t_crossing r;
        d1x = longint'(s.q1x) - longint'(s.p1x);
        d1y = longint'(s.q1y) - longint'(s.p1y);
        d2x = longint'(s.q2x) - longint'(s.p2x);
        d2y = longint'(s.q2y) - longint'(s.p2y);
        rx  = longint'(s.p2x) - longint'(s.p1x);
        ry  = longint'(s.p2y) - longint'(s.p1y);
        den = d1x * d2y - d1y * d2x;
        sn  = rx * d2y - ry * d2x;
        tn  = rx * d1y - ry * d1x;
        if (den < 0) begin
            den = -den;
            sn  = -sn;
            tn  = -tn;
        end
        r.found = (den != 0) && (sn > 0) && (sn < den) && (tn > 0) && (tn < den);
        r.x = '0;
        r.y = '0;
        if (r.found) begin
            r.x = OW'(point_along(longint'(s.p1x), d1x, sn, den));
            r.y = OW'(point_along(longint'(s.p1y), d1y, sn, den));
        end
        return r;
    endfunction

    function automatic void add_pair(int ax, int ay, int bx, int by,
                                     int cx, int cy, int dx, int dy);
        t_segment_pair s;
        s.p1x = CW'(ax);
        s.p1y = CW'(ay);
        s.q1x = CW'(bx);
        s.q1y = CW'(by);
        s.p2x = CW'(cx);
        s.p2y = CW'(cy);
        s.q2x = CW'(dx);
        s.q2y = CW'(dy);
        pending_pairs.push_back(s);
    endfunction

    function automatic int any_coord();
        return $urandom_range(0, 32767) - 16384;
    endfunction

    function automatic int near(int base);
        return base + $urandom_range(0, 6);
    endfunction

    function automatic int jit();
        return $urandom_range(0, 4) - 2;
    endfunction

    function automatic void add_random_pair();
        int kind, bx, by, mx, my, ux, uy, vx, vy;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            add_pair(any_coord(), any_coord(), any_coord(), any_coord(),
                     any_coord(), any_coord(), any_coord(), any_coord());
        end else if (kind < 75) begin
            // tight box, lots of parallel, collinear and touching cases
            bx = $urandom_range(0, 32760) - 16384;
            by = $urandom_range(0, 32760) - 16384;
            add_pair(near(bx), near(by), near(bx), near(by),
                     near(bx), near(by), near(bx), near(by));
        end else begin
            // two segments built around a shared midpoint
            mx = $urandom_range(0, 16000) - 8000;
            my = $urandom_range(0, 16000) - 8000;
            ux = $urandom_range(0, 16000) - 8000;
            uy = $urandom_range(0, 16000) - 8000;
            vx = $urandom_range(0, 16000) - 8000;
            vy = $urandom_range(0, 16000) - 8000;
            add_pair(mx - ux, my - uy, mx + ux + jit(), my + uy + jit(),
                     mx - vx, my - vy, mx + vx + jit(), my + vy + jit());
        end
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_crossings.push_back(predict_crossing(cur_pair));
                n_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    cur_pair = pending_pairs.pop_front();
                    i_first_p_x  <= cur_pair.p1x;
                    i_first_p_y  <= cur_pair.p1y;
                    i_first_q_x  <= cur_pair.q1x;
                    i_first_q_y  <= cur_pair.q1y;
                    i_second_p_x <= cur_pair.p2x;
                    i_second_p_y <= cur_pair.p2y;
                    i_second_q_x <= cur_pair.q2x;
                    i_second_q_y <= cur_pair.q2y;
                    i_in_valid   <= 1'b1;
                    if ($urandom_range(0, 59) == 0)
                        in_burst = !in_burst;
                    in_gap = in_burst ? 0 : pick_idle();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        t_crossing want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_received++;
                if (expected_crossings.size() == 0) begin
                    n_fail++;
                    if (n_mismatch < 10)
                        $display("unexpected transfer: found=%0d x=%0d y=%0d",
                                 o_found, o_cross_x, o_cross_y);
                    n_mismatch++;
                end else begin
                    want = expected_crossings.pop_front();
                    if (o_found !== want.found || o_cross_x !== want.x
                            || o_cross_y !== want.y) begin
                        n_fail++;
                        if (n_mismatch < 10)
                            $display("mismatch %0d: exp %0d %0d %0d, got %0d %0d %0d",
                                     n_received, want.found, want.x, want.y,
                                     o_found, o_cross_x, o_cross_y);
                        n_mismatch++;
                    end
                end
            end
            if ($urandom_range(0, 199) == 0)
                out_burst = !out_burst;
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!out_burst && $urandom_range(0, 3) == 0)
                    out_stall = pick_idle();
            end
        end
    end

    initial begin
        // crossings, with fractions of both signs
        add_pair(0, 0, 4, 4, 0, 4, 4, 0);
        add_pair(0, 0, 3, 1, 1, -1, 1, 2);
        add_pair(0, 0, -3, -1, -1, 1, -1, -2);
        add_pair(-16384, -3, -16381, -2, -16383, -4, -16382, 0);
        // parallel, collinear, zero length
        add_pair(0, 0, 5, 5, 1, 0, 6, 5);
        add_pair(0, 0, 4, 0, 2, 0, 6, 0);
        add_pair(1, 1, 1, 1, 0, 0, 2, 2);
        add_pair(0, 0, 4, 4, 2, 2, 2, 2);
        // touches at each endpoint
        add_pair(0, 0, 4, 0, 0, -2, 0, 2);
        add_pair(0, 0, 4, 0, 4, -2, 4, 2);
        add_pair(0, 0, 4, 0, 2, 0, 2, 3);
        add_pair(0, 0, 4, 0, 2, 3, 2, 0);
        add_pair(2, 0, 2, 5, 0, 0, 4, 0);
        add_pair(0, 0, 4, 4, 4, 4, 8, 0);
        // crossing beyond one segment
        add_pair(0, 0, 1, 0, 3, -1, 3, 1);
        add_pair(0, 0, 4, 0, 2, 1, 2, 5);
        // extremes of the coordinate range
        add_pair(-16384, -16384, 16383, 16383, -16384, 16383, 16383, -16384);
        add_pair(-16384, 16383, 16383, -16384, -16384, -16384, 16383, 16383);
        add_pair(16383, 16383, 16383, 16383, 16383, 16383, 16383, 16383);
        add_pair(-16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384);
        add_pair(-16384, 0, 16383, 1, 0, -16384, 1, 16383);
        add_pair(16383, -16384, -16384, 16383, -16384, -16383, 16383, 16382);
        add_pair(-16384, -16384, 16383, 16382, -16384, -16383, 16383, 16381);
        for (int i = 0; i < N_RANDOM; i++)
            add_random_pair();
        n_total = pending_pairs.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_sent == n_total);
        wait (n_received >= n_total);
        repeat (END_WAIT) @(posedge i_clk);
        if (expected_crossings.size() != 0) begin
            n_fail++;
            $display("%0d results never arrived", expected_crossings.size());
        end
        if (n_fail == 0)
            $display("tb_segment_intersection_point_top passed");
        else
            $display("tb_segment_intersection_point_top failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_segment_intersection_point_top failed");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/sip_pkg.sv
hdl/sip_front.sv
hdl/sip_div.sv
hdl/segment_intersection_point_top.sv
tb/sv/tb_segment_intersection_point_top.sv
